// ----- hdl/hwc_pkg.sv -----
package hwc_pkg;

    localparam int C_MAX_CELLS_PER_SIDE = 16;
    localparam int C_PITCH_BITS         = 24;

    localparam int C_IDX_W   = 5;
    localparam int C_PLACE_W = 4;
    localparam int C_N_W     = 5;
    localparam int C_COORD_W = 10;
    localparam int C_POS_W   = 32;
    localparam int C_EDGE_W  = 4;
    localparam int C_EX_W    = 4;
    localparam int C_CFG_IDX_W = 3;

    localparam logic [C_CFG_IDX_W-1:0] C_REG_FINE_N   = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_COARSE_N = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_FINE_PX  = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_FINE_PY  = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_COARSE_PX = 3'd4;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_COARSE_PY = 3'd5;

    localparam logic [C_N_W-1:0] C_RST_FINE_N   = 5'd16;
    localparam logic [C_N_W-1:0] C_RST_COARSE_N = 5'd8;
    localparam int C_RST_FINE_PX   = 228600;
    localparam int C_RST_FINE_PY   = 197974;
    localparam int C_RST_COARSE_PX = 457200;
    localparam int C_RST_COARSE_PY = 395948;

    localparam logic [C_PLACE_W-1:0] C_LAST_PLACE  = 4'd11;
    localparam logic [C_PLACE_W-1:0] C_FIRST_OTHER_FACE = 4'd6;

    typedef enum logic [1:0] {
        KIND_FULL   = 2'd0,
        KIND_CORNER = 2'd1,
        KIND_TRUNC  = 2'd2,
        KIND_EXT    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [C_IDX_W-1:0]   u_index;
        logic [C_IDX_W-1:0]   v_index;
        logic [C_PLACE_W-1:0] placement;
        logic                 density_type;
    } t_in_word;

    typedef struct packed {
        logic signed [C_POS_W-1:0] x_pos;
        logic signed [C_POS_W-1:0] y_pos;
        logic [C_EDGE_W-1:0]       edge_code;
        logic [1:0]                cell_kind;
    } t_out_word;

    typedef struct packed {
        logic [C_EDGE_W-1:0] edge_code;
        t_kind               cell_kind;
    } t_tag;

    localparam logic [C_EDGE_W-1:0] C_EDGE_TAB [0:11][0:12] = '{
        '{4'd0, 4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd0,  4'd1, 4'd2, 4'd0, 4'd0, 4'd1, 4'd2},
        '{4'd0, 4'd8,  4'd9,  4'd10, 4'd11, 4'd6,  4'd7,  4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd3},
        '{4'd0, 4'd3,  4'd4,  4'd5,  4'd0,  4'd1,  4'd2,  4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0},
        '{4'd0, 4'd10, 4'd11, 4'd6,  4'd7,  4'd8,  4'd9,  4'd5, 4'd3, 4'd4, 4'd5, 4'd3, 4'd4},
        '{4'd0, 4'd5,  4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd0, 4'd1, 4'd2, 4'd2, 4'd0, 4'd1},
        '{4'd0, 4'd6,  4'd7,  4'd8,  4'd9,  4'd10, 4'd11, 4'd3, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5},
        '{4'd0, 4'd7,  4'd8,  4'd9,  4'd10, 4'd11, 4'd6,  4'd3, 4'd4, 4'd5, 4'd4, 4'd5, 4'd3},
        '{4'd0, 4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd0, 4'd1, 4'd2, 4'd0, 4'd1, 4'd2},
        '{4'd0, 4'd11, 4'd6,  4'd7,  4'd8,  4'd9,  4'd10, 4'd5, 4'd3, 4'd4, 4'd3, 4'd4, 4'd5},
        '{4'd0, 4'd4,  4'd5,  4'd0,  4'd1,  4'd2,  4'd3,  4'd2, 4'd0, 4'd1, 4'd2, 4'd0, 4'd1},
        '{4'd0, 4'd9,  4'd10, 4'd11, 4'd6,  4'd7,  4'd8,  4'd4, 4'd5, 4'd3, 4'd5, 4'd3, 4'd4},
        '{4'd0, 4'd2,  4'd3,  4'd4,  4'd5,  4'd0,  4'd1,  4'd1, 4'd2, 4'd0, 4'd1, 4'd2, 4'd0}
    };

endpackage

// ----- hdl/hwc_cfg.sv -----
module hwc_cfg #(
    parameter int PITCH_BITS = hwc_pkg::C_PITCH_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hwc_pkg::C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PITCH_BITS-1:0]         i_cfg_data,
    output logic [hwc_pkg::C_N_W-1:0]     o_fine_n,
    output logic [hwc_pkg::C_N_W-1:0]     o_coarse_n,
    output logic [PITCH_BITS-1:0]         o_fine_px,
    output logic [PITCH_BITS-1:0]         o_fine_py,
    output logic [PITCH_BITS-1:0]         o_coarse_px,
    output logic [PITCH_BITS-1:0]         o_coarse_py
);

    logic [hwc_pkg::C_N_W-1:0] r_fine_n;
    logic [hwc_pkg::C_N_W-1:0] r_coarse_n;
    logic [PITCH_BITS-1:0]     r_fine_px;
    logic [PITCH_BITS-1:0]     r_fine_py;
    logic [PITCH_BITS-1:0]     r_coarse_px;
    logic [PITCH_BITS-1:0]     r_coarse_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine_n    <= hwc_pkg::C_RST_FINE_N;
            r_coarse_n  <= hwc_pkg::C_RST_COARSE_N;
            r_fine_px   <= PITCH_BITS'(hwc_pkg::C_RST_FINE_PX);
            r_fine_py   <= PITCH_BITS'(hwc_pkg::C_RST_FINE_PY);
            r_coarse_px <= PITCH_BITS'(hwc_pkg::C_RST_COARSE_PX);
            r_coarse_py <= PITCH_BITS'(hwc_pkg::C_RST_COARSE_PY);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hwc_pkg::C_REG_FINE_N:    r_fine_n    <= i_cfg_data[hwc_pkg::C_N_W-1:0];
                hwc_pkg::C_REG_COARSE_N:  r_coarse_n  <= i_cfg_data[hwc_pkg::C_N_W-1:0];
                hwc_pkg::C_REG_FINE_PX:   r_fine_px   <= i_cfg_data;
                hwc_pkg::C_REG_FINE_PY:   r_fine_py   <= i_cfg_data;
                hwc_pkg::C_REG_COARSE_PX: r_coarse_px <= i_cfg_data;
                hwc_pkg::C_REG_COARSE_PY: r_coarse_py <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_fine_n    = r_fine_n;
    assign o_coarse_n  = r_coarse_n;
    assign o_fine_px   = r_fine_px;
    assign o_fine_py   = r_fine_py;
    assign o_coarse_px = r_coarse_px;
    assign o_coarse_py = r_coarse_py;

endmodule

// ----- hdl/hwc_geom.sv -----
module hwc_geom #(
    parameter int MAX_CELLS_PER_SIDE = hwc_pkg::C_MAX_CELLS_PER_SIDE,
    parameter int PITCH_BITS         = hwc_pkg::C_PITCH_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  hwc_pkg::t_in_word                     i_item,
    input  logic [hwc_pkg::C_N_W-1:0]             i_fine_n,
    input  logic [hwc_pkg::C_N_W-1:0]             i_coarse_n,
    input  logic [PITCH_BITS-1:0]                 i_fine_px,
    input  logic [PITCH_BITS-1:0]                 i_fine_py,
    input  logic [PITCH_BITS-1:0]                 i_coarse_px,
    input  logic [PITCH_BITS-1:0]                 i_coarse_py,
    output logic                                  o_valid,
    output logic signed [hwc_pkg::C_COORD_W-1:0]  o_hx,
    output logic signed [hwc_pkg::C_COORD_W-1:0]  o_ky,
    output logic [PITCH_BITS-1:0]                 o_px,
    output logic [PITCH_BITS-1:0]                 o_py,
    output hwc_pkg::t_tag                         o_tag
);

    localparam int NW = $clog2(MAX_CELLS_PER_SIDE + 1);
    localparam int CW = hwc_pkg::C_COORD_W;
    localparam int CMPW = (NW > hwc_pkg::C_N_W ? NW : hwc_pkg::C_N_W) + 1;

    // stage one: pick density, clamp count and placement
    logic                              r_s1_vld;
    logic [hwc_pkg::C_IDX_W-1:0]       r_s1_u;
    logic [hwc_pkg::C_IDX_W-1:0]       r_s1_v;
    logic [hwc_pkg::C_PLACE_W-1:0]     r_s1_p;
    logic [NW-1:0]                     r_s1_n;
    logic [PITCH_BITS-1:0]             r_s1_px;
    logic [PITCH_BITS-1:0]             r_s1_py;

    logic [hwc_pkg::C_N_W-1:0]         n_raw;
    logic [NW-1:0]                     n_s1_n;
    logic [hwc_pkg::C_PLACE_W-1:0]     n_s1_p;

    always_comb begin
        n_raw = i_item.density_type ? i_coarse_n : i_fine_n;
        if (n_raw == '0) begin
            n_s1_n = NW'(1);
        end else if (CMPW'(n_raw) > CMPW'(MAX_CELLS_PER_SIDE)) begin
            n_s1_n = NW'(MAX_CELLS_PER_SIDE);
        end else begin
            n_s1_n = NW'(n_raw);
        end
        n_s1_p = (i_item.placement > hwc_pkg::C_LAST_PLACE) ? hwc_pkg::C_LAST_PLACE
                                                             : i_item.placement;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_u  <= i_item.u_index;
        r_s1_v  <= i_item.v_index;
        r_s1_p  <= n_s1_p;
        r_s1_n  <= n_s1_n;
        r_s1_px <= i_item.density_type ? i_coarse_px : i_fine_px;
        r_s1_py <= i_item.density_type ? i_coarse_py : i_fine_py;
    end

    // stage two: linear placement formulas and edge classification
    logic signed [CW-1:0] su, sv, sn, nm1, last, d_uv, d_vu;
    logic signed [CW-1:0] n_hx, n_ky;
    logic [hwc_pkg::C_EX_W-1:0] ex;
    hwc_pkg::t_kind kind;

    always_comb begin
        su   = signed'(CW'(r_s1_u));
        sv   = signed'(CW'(r_s1_v));
        sn   = signed'(CW'(r_s1_n));
        nm1  = CW'(sn - 1);
        last = CW'(2 * sn - 1);
        d_uv = CW'(su - sv);
        d_vu = CW'(sv - su);

        case (r_s1_p)
            4'd0: begin
                n_hx = CW'(3 * d_uv - 1);       n_ky = CW'(su + sv - 2 * sn + 1);
            end
            4'd1: begin
                n_hx = CW'(-(3 * (sv - sn) + 2)); n_ky = CW'(2 * su - sv - sn);
            end
            4'd2: begin
                n_hx = CW'(-(3 * (su - sn) + 1)); n_ky = CW'(-(2 * sv - su - sn + 1));
            end
            4'd3: begin
                n_hx = CW'(-(3 * d_uv - 1));    n_ky = CW'(-(su + sv - 2 * sn + 1));
            end
            4'd4: begin
                n_hx = CW'(3 * (sv - sn) + 2);  n_ky = CW'(-(2 * su - sv - sn));
            end
            4'd5: begin
                n_hx = CW'(3 * (su - sn) + 1);  n_ky = CW'(2 * sv - su - sn + 1);
            end
            4'd6: begin
                n_hx = CW'(3 * d_vu + 1);       n_ky = CW'(su + sv - 2 * sn + 1);
            end
            4'd7: begin
                n_hx = CW'(3 * (sv - sn) + 2);  n_ky = CW'(2 * su - sv - sn);
            end
            4'd8: begin
                n_hx = CW'(3 * (su - sn) + 1);  n_ky = CW'(-(2 * sv - su - sn + 1));
            end
            4'd9: begin
                n_hx = CW'(-(3 * d_vu + 1));    n_ky = CW'(-(su + sv - 2 * sn + 1));
            end
            4'd10: begin
                n_hx = CW'(-(3 * (sv - sn) + 2)); n_ky = CW'(-(2 * su - sv - sn));
            end
            default: begin
                n_hx = CW'(-(3 * (su - sn) + 1)); n_ky = CW'(2 * sv - su - sn + 1);
            end
        endcase

        ex   = 4'd0;
        kind = hwc_pkg::KIND_FULL;
        if (r_s1_p >= hwc_pkg::C_FIRST_OTHER_FACE) begin
            if (su == 0 && sv == 0) begin
                ex = 4'd1;  kind = hwc_pkg::KIND_CORNER;
            end else if (su == 0 && d_vu == nm1) begin
                ex = 4'd2;  kind = hwc_pkg::KIND_CORNER;
            end else if (d_vu == nm1 && sv == last) begin
                ex = 4'd3;  kind = hwc_pkg::KIND_CORNER;
            end else if (su == last && sv == last) begin
                ex = 4'd4;  kind = hwc_pkg::KIND_CORNER;
            end else if (su == last && d_uv == sn) begin
                ex = 4'd5;  kind = hwc_pkg::KIND_CORNER;
            end else if (d_uv == sn && sv == 0) begin
                ex = 4'd6;  kind = hwc_pkg::KIND_CORNER;
            end else if (su == 0) begin
                ex = 4'd7;  kind = hwc_pkg::KIND_TRUNC;
            end else if (d_vu == nm1) begin
                ex = 4'd10; kind = hwc_pkg::KIND_EXT;
            end else if (sv == last) begin
                ex = 4'd8;  kind = hwc_pkg::KIND_TRUNC;
            end else if (su == last) begin
                ex = 4'd11; kind = hwc_pkg::KIND_EXT;
            end else if (d_uv == sn) begin
                ex = 4'd9;  kind = hwc_pkg::KIND_TRUNC;
            end else if (sv == 0) begin
                ex = 4'd12; kind = hwc_pkg::KIND_EXT;
            end
        end else begin
            if (su == 0 && sv == 0) begin
                ex = 4'd1;  kind = hwc_pkg::KIND_CORNER;
            end else if (sv == 0 && d_uv == sn) begin
                ex = 4'd2;  kind = hwc_pkg::KIND_CORNER;
            end else if (d_uv == sn && su == last) begin
                ex = 4'd3;  kind = hwc_pkg::KIND_CORNER;
            end else if (su == last && sv == last) begin
                ex = 4'd4;  kind = hwc_pkg::KIND_CORNER;
            end else if (sv == last && d_vu == nm1) begin
                ex = 4'd5;  kind = hwc_pkg::KIND_CORNER;
            end else if (d_vu == nm1 && su == 0) begin
                ex = 4'd6;  kind = hwc_pkg::KIND_CORNER;
            end else if (sv == 0) begin
                ex = 4'd10; kind = hwc_pkg::KIND_EXT;
            end else if (d_uv == sn) begin
                ex = 4'd7;  kind = hwc_pkg::KIND_TRUNC;
            end else if (su == last) begin
                ex = 4'd11; kind = hwc_pkg::KIND_EXT;
            end else if (sv == last) begin
                ex = 4'd8;  kind = hwc_pkg::KIND_TRUNC;
            end else if (d_vu == nm1) begin
                ex = 4'd12; kind = hwc_pkg::KIND_EXT;
            end else if (su == 0) begin
                ex = 4'd9;  kind = hwc_pkg::KIND_TRUNC;
            end
        end
    end

    logic                 r_s2_vld;
    logic signed [CW-1:0] r_s2_hx;
    logic signed [CW-1:0] r_s2_ky;
    logic [PITCH_BITS-1:0] r_s2_px;
    logic [PITCH_BITS-1:0] r_s2_py;
    hwc_pkg::t_tag        r_s2_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_hx            <= n_hx;
        r_s2_ky            <= n_ky;
        r_s2_px            <= r_s1_px;
        r_s2_py            <= r_s1_py;
        r_s2_tag.edge_code <= hwc_pkg::C_EDGE_TAB[r_s1_p][ex];
        r_s2_tag.cell_kind <= kind;
    end

    assign o_valid = r_s2_vld;
    assign o_hx    = r_s2_hx;
    assign o_ky    = r_s2_ky;
    assign o_px    = r_s2_px;
    assign o_py    = r_s2_py;
    assign o_tag   = r_s2_tag;

endmodule

// ----- hdl/hwc_scale.sv -----
module hwc_scale #(
    parameter int PITCH_BITS = hwc_pkg::C_PITCH_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [hwc_pkg::C_COORD_W-1:0] i_hx,
    input  logic signed [hwc_pkg::C_COORD_W-1:0] i_ky,
    input  logic [PITCH_BITS-1:0]                i_px,
    input  logic [PITCH_BITS-1:0]                i_py,
    input  hwc_pkg::t_tag                        i_tag,
    output logic                                 o_strobe,
    output hwc_pkg::t_out_word                   o_result
);

    localparam int PW = PITCH_BITS + hwc_pkg::C_COORD_W + 1;
    localparam int YW = PW + 1;
    localparam int WW = 64;

    // stage three: pitch multiply
    logic                 r_s3_vld;
    logic signed [PW-1:0] r_s3_x;
    logic signed [PW-1:0] r_s3_ky;
    hwc_pkg::t_tag        r_s3_tag;

    logic signed [PW-1:0] x_prod;
    logic signed [PW-1:0] y_prod;

    assign x_prod = i_hx * $signed({1'b0, i_px});
    assign y_prod = i_ky * $signed({1'b0, i_py});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_x   <= x_prod;
        r_s3_ky  <= y_prod;
        r_s3_tag <= i_tag;
    end

    // stage four: double y and saturate to the output range
    logic signed [YW-1:0] y_dbl;
    logic signed [WW-1:0] x_wide;
    logic signed [WW-1:0] y_wide;
    logic signed [hwc_pkg::C_POS_W-1:0] n_x;
    logic signed [hwc_pkg::C_POS_W-1:0] n_y;

    localparam logic signed [WW-1:0] C_POS_MAX = 64'sd2147483647;
    localparam logic signed [WW-1:0] C_POS_MIN = -64'sd2147483648;

    always_comb begin
        y_dbl  = YW'(r_s3_ky) <<< 1;
        x_wide = WW'(r_s3_x);
        y_wide = WW'(y_dbl);
        if (x_wide > C_POS_MAX) begin
            n_x = C_POS_MAX[hwc_pkg::C_POS_W-1:0];
        end else if (x_wide < C_POS_MIN) begin
            n_x = C_POS_MIN[hwc_pkg::C_POS_W-1:0];
        end else begin
            n_x = x_wide[hwc_pkg::C_POS_W-1:0];
        end
        if (y_wide > C_POS_MAX) begin
            n_y = C_POS_MAX[hwc_pkg::C_POS_W-1:0];
        end else if (y_wide < C_POS_MIN) begin
            n_y = C_POS_MIN[hwc_pkg::C_POS_W-1:0];
        end else begin
            n_y = y_wide[hwc_pkg::C_POS_W-1:0];
        end
    end

    logic               r_s4_vld;
    hwc_pkg::t_out_word r_s4_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_res.x_pos     <= n_x;
        r_s4_res.y_pos     <= n_y;
        r_s4_res.edge_code <= r_s3_tag.edge_code;
        r_s4_res.cell_kind <= r_s3_tag.cell_kind;
    end

    assign o_strobe = r_s4_vld;
    assign o_result = r_s4_res;

endmodule

// ----- hdl/hex_wafer_cell_position_and_kind.sv -----
// hexagonal wafer cell locator: takes one word per clock (busy is never raised) and
// returns one result word per word taken, marked by o_strobe for one cycle; the four
// stages are input select and clamp, placement formulas and edge tables, the pitch
// multipliers, and saturation into the output register. the receiver cannot stall, so
// every result must be taken in its strobe cycle. the user must write configuration
// via i_cfg_we, i_cfg_idx, i_cfg_data only while no word is in flight; not enforced.
module hex_wafer_cell_position_and_kind #(
    parameter int MAX_CELLS_PER_SIDE = hwc_pkg::C_MAX_CELLS_PER_SIDE,
    parameter int PITCH_BITS         = hwc_pkg::C_PITCH_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  hwc_pkg::t_in_word               i_item,
    output logic                            o_strobe,
    output hwc_pkg::t_out_word              o_result,
    input  logic                            i_cfg_we,
    input  logic [hwc_pkg::C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PITCH_BITS-1:0]           i_cfg_data
);

    logic [hwc_pkg::C_N_W-1:0] fine_n;
    logic [hwc_pkg::C_N_W-1:0] coarse_n;
    logic [PITCH_BITS-1:0]     fine_px;
    logic [PITCH_BITS-1:0]     fine_py;
    logic [PITCH_BITS-1:0]     coarse_px;
    logic [PITCH_BITS-1:0]     coarse_py;

    logic                                 geom_vld;
    logic signed [hwc_pkg::C_COORD_W-1:0] geom_hx;
    logic signed [hwc_pkg::C_COORD_W-1:0] geom_ky;
    logic [PITCH_BITS-1:0]                geom_px;
    logic [PITCH_BITS-1:0]                geom_py;
    hwc_pkg::t_tag                        geom_tag;

    assign busy = 1'b0;

    hwc_cfg #(
        .PITCH_BITS (PITCH_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_fine_n    (fine_n),
        .o_coarse_n  (coarse_n),
        .o_fine_px   (fine_px),
        .o_fine_py   (fine_py),
        .o_coarse_px (coarse_px),
        .o_coarse_py (coarse_py)
    );

    hwc_geom #(
        .MAX_CELLS_PER_SIDE (MAX_CELLS_PER_SIDE),
        .PITCH_BITS         (PITCH_BITS)
    ) u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start && !busy),
        .i_item      (i_item),
        .i_fine_n    (fine_n),
        .i_coarse_n  (coarse_n),
        .i_fine_px   (fine_px),
        .i_fine_py   (fine_py),
        .i_coarse_px (coarse_px),
        .i_coarse_py (coarse_py),
        .o_valid     (geom_vld),
        .o_hx        (geom_hx),
        .o_ky        (geom_ky),
        .o_px        (geom_px),
        .o_py        (geom_py),
        .o_tag       (geom_tag)
    );

    hwc_scale #(
        .PITCH_BITS (PITCH_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (geom_vld),
        .i_hx     (geom_hx),
        .i_ky     (geom_ky),
        .i_px     (geom_px),
        .i_py     (geom_py),
        .i_tag    (geom_tag),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ----- hdl/hwc_checker.sv -----
module hwc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input hwc_pkg::t_in_word  i_item,
    input logic               o_strobe,
    input hwc_pkg::t_out_word o_result
);

    // every word taken comes out as a strobed result
    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("accepted word gave no result");

    // no result without an earlier word taken
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 4))
        else $error("result without accepted word");

    // a full cell has no orientation code
    a_full_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.cell_kind == hwc_pkg::KIND_FULL) |-> o_result.edge_code == '0)
        else $error("full cell with edge code");

    // the origin cell is always a corner
    a_origin_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.u_index == '0 && i_item.v_index == '0)
        |-> ##4 (o_result.cell_kind == hwc_pkg::KIND_CORNER))
        else $error("origin cell not a corner");

endmodule

bind hex_wafer_cell_position_and_kind hwc_checker u_hwc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
